/* rtl/inflight_command_tracker_assert.svh */
// Assertion macros for the inflight command tracker checker.
`ifndef INFLIGHT_COMMAND_TRACKER_ASSERT_SVH
`define INFLIGHT_COMMAND_TRACKER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ICT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ict check failed");

// Next-cycle implication, checked outside reset.
`define ICT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ict check failed");

`endif

/* rtl/ict_pkg.sv */
// ----------------------------------------------------------------------------
// ict_pkg
// Types and codes shared by the inflight command tracker modules.
// ----------------------------------------------------------------------------
package ict_pkg;

	localparam logic [1:0] CMD_SEND  = 2'd0;
	localparam logic [1:0] CMD_RESP  = 2'd1;
	localparam logic [1:0] CMD_TICK  = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	localparam logic [3:0] K_SENT      = 4'd0;
	localparam logic [3:0] K_FULL      = 4'd1;
	localparam logic [3:0] K_MATCHED   = 4'd2;
	localparam logic [3:0] K_UNMATCHED = 4'd3;
	localparam logic [3:0] K_BAD_TYPE  = 4'd4;
	localparam logic [3:0] K_RESEND    = 4'd5;
	localparam logic [3:0] K_TIMEOUT   = 4'd6;
	localparam logic [3:0] K_TICK_DONE = 4'd7;
	localparam logic [3:0] K_QUERY     = 4'd8;

	localparam logic [3:0] MT_AEM_RESP  = 4'd1;
	localparam logic [3:0] MT_AA_RESP   = 4'd3;

	localparam int         NW         = 5;
	localparam logic [NW-1:0] MAX_RES = 5'd16;
	localparam logic [15:0] TMO_RESET = 16'd250;

	typedef struct packed {
		logic        valid;
		logic [15:0] seq;
		logic [15:0] tag;
		logic        flag;
		logic        retried;
		logic [15:0] timer;
	} entry_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] seq;
		logic [15:0] tag;
		logic        flag;
		logic [3:0]  slot;
		logic        found;
	} res_t;

	// walk control seen by the head cell
	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] tag;
		logic        flag;
		logic [15:0] rseq;
		logic        type_ok;
		logic        done;
		logic        budget_spent;
		logic [15:0] tmo;
		logic [15:0] next_seq;
	} ctrl_t;

	typedef struct packed {
		logic hit;
		res_t res;
	} hit_t;

endpackage

/* rtl/ict_cell.sv */
// ----------------------------------------------------------------------------
// ict_cell
// One table entry of the ring; takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module ict_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            shift,
	input  ict_pkg::entry_t d,
	output ict_pkg::entry_t q
);
	import ict_pkg::*;

	logic   valid_q;
	entry_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= d.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	always_comb begin
		q       = data_q;
		q.valid = valid_q;
	end

endmodule

/* rtl/ict_head.sv */
// ----------------------------------------------------------------------------
// ict_head
// Per-entry update at the head of the ring for the item being walked.
// ----------------------------------------------------------------------------
module ict_head (
	input  ict_pkg::ctrl_t  ctrl,
	input  ict_pkg::entry_t cur,
	input  logic [3:0]      slot_idx,
	output ict_pkg::entry_t nxt,
	output ict_pkg::hit_t   hd
);
	import ict_pkg::*;

	always_comb begin
		nxt = cur;
		hd  = '0;
		case (ctrl.cmd)
			CMD_SEND: begin
				if (!ctrl.done && !cur.valid) begin
					nxt.valid   = 1'b1;
					nxt.seq     = ctrl.next_seq;
					nxt.tag     = ctrl.tag;
					nxt.flag    = ctrl.flag;
					nxt.retried = 1'b0;
					nxt.timer   = ctrl.tmo;
					hd.hit      = 1'b1;
					hd.res      = '{K_SENT, ctrl.next_seq, ctrl.tag, ctrl.flag, slot_idx, 1'b0};
				end
			end
			CMD_RESP: begin
				if (ctrl.type_ok && !ctrl.done && cur.valid && cur.seq == ctrl.rseq) begin
					nxt.valid = 1'b0;
					hd.hit    = 1'b1;
					hd.res    = '{K_MATCHED, cur.seq, cur.tag, cur.flag, slot_idx, 1'b0};
				end
			end
			CMD_TICK: begin
				if (cur.valid) begin
					if (cur.timer > 16'd1) begin
						nxt.timer = cur.timer - 16'd1;
					end else if (!ctrl.budget_spent) begin
						hd.hit = 1'b1;
						if (!cur.retried) begin
							nxt.retried = 1'b1;
							nxt.timer   = ctrl.tmo;
							hd.res = '{K_RESEND, cur.seq, cur.tag, cur.flag, slot_idx, 1'b0};
						end else begin
							nxt.valid = 1'b0;
							hd.res = '{K_TIMEOUT, cur.seq, cur.tag, cur.flag, slot_idx, 1'b0};
						end
					end
				end
			end
			default: begin
				if (!ctrl.done && cur.valid && cur.tag == ctrl.tag) begin
					hd.hit = 1'b1;
					hd.res = '{K_QUERY, cur.seq, cur.tag, cur.flag, slot_idx, 1'b1};
				end
			end
		endcase
	end

endmodule

/* rtl/inflight_command_tracker.sv */
// ----------------------------------------------------------------------------
// inflight_command_tracker
// Table of outstanding commands kept in a rotating ring of entry cells.
// ----------------------------------------------------------------------------
// After an item is accepted, the ring rotates one slot per cycle past the head cell
// while no output stall holds it, then the final result is loaded into the output.
// A stalled output holds things up: each extra tick result and the final one wait.
// Reset empties the table, zeroes the sequence counter, sets timeout to 250.
// One item in flight at a time; in_stall stays high while an item is walked.
module inflight_command_tracker #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] tag,
	input  logic        notify_flag,
	input  logic [15:0] resp_seq,
	input  logic [3:0]  resp_type,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  kind,
	output logic [15:0] seq_out,
	output logic [15:0] tag_out,
	output logic        flag_out,
	output logic [3:0]  slot,
	output logic        found,
	output logic        last
);
	import ict_pkg::*;

	localparam int CW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [CW-1:0] LastIdx = CW'(TABLE_DEPTH - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_FIN} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    cmd_q;
	logic [15:0]   tag_q;
	logic          flag_q;
	logic [15:0]   rseq_q;
	logic          type_ok_q;
	logic          done_q;
	logic [NW-1:0] n_q;
	logic [15:0]   next_seq_q;
	logic [15:0]   tmo_q;
	logic          pend_v_q;
	res_t          pend_q;
	logic          out_v_q;
	res_t          out_q;
	logic          out_last_q;

	entry_t ring [TABLE_DEPTH];
	entry_t head_nxt;
	ctrl_t  ctrl;
	hit_t   hd;
	res_t   dflt;
	logic   out_busy;
	logic   step;
	logic   push_pend;
	logic   fin_go;

	// Cell 0 is the head; entries move toward it, the processed head
	// entry re-enters at the tail. After TABLE_DEPTH shifts the ring is
	// back in slot order.
	for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_ring
		if (k == TABLE_DEPTH - 1) begin : g_tail
			ict_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(step),
				.d(head_nxt), .q(ring[k]));
		end else begin : g_mid
			ict_cell u_cell (.clk(clk), .arst_n(arst_n), .shift(step),
				.d(ring[k+1]), .q(ring[k]));
		end
	end

	always_comb begin
		ctrl.cmd          = cmd_q;
		ctrl.tag          = tag_q;
		ctrl.flag         = flag_q;
		ctrl.rseq         = rseq_q;
		ctrl.type_ok      = type_ok_q;
		ctrl.done         = done_q;
		ctrl.budget_spent = (n_q >= MAX_RES);
		ctrl.tmo          = tmo_q;
		ctrl.next_seq     = next_seq_q;
	end

	ict_head u_head (
		.ctrl(ctrl), .cur(ring[0]), .slot_idx(4'(cnt_q)), .nxt(head_nxt), .hd(hd)
	);

	assign out_busy = out_v_q && out_stall;
	// A hit pushes the pending result out; hold the ring if that can't happen.
	assign step = (state_q == ST_WALK) && !(hd.hit && pend_v_q && out_busy);
	// earlier tick result moves to the output, it is not the final one
	assign push_pend = step && hd.hit && pend_v_q;
	assign fin_go    = (state_q == ST_FIN) && !out_busy;

	// Result when nothing in the table answered the item.
	always_comb begin
		dflt = '0;
		case (cmd_q)
			CMD_SEND: dflt.kind = K_FULL;
			CMD_RESP: dflt.kind = type_ok_q ? K_UNMATCHED : K_BAD_TYPE;
			CMD_TICK: dflt.kind = K_TICK_DONE;
			default:  dflt.kind = K_QUERY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			cmd_q      <= CMD_SEND;
			tag_q      <= '0;
			flag_q     <= 1'b0;
			rseq_q     <= '0;
			type_ok_q  <= 1'b0;
			done_q     <= 1'b0;
			n_q        <= '0;
			next_seq_q <= '0;
			tmo_q      <= TMO_RESET;
			pend_v_q   <= 1'b0;
			pend_q     <= '0;
			out_v_q    <= 1'b0;
			out_q      <= '0;
			out_last_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tmo_q <= cfg_wdata;
			end
			if (push_pend || fin_go) begin
				out_q      <= (fin_go && !pend_v_q) ? dflt : pend_q;
				out_v_q    <= 1'b1;
				out_last_q <= fin_go;
			end else if (out_v_q && !out_stall) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q     <= cmd;
						tag_q     <= tag;
						flag_q    <= notify_flag;
						rseq_q    <= resp_seq;
						type_ok_q <= (resp_type == MT_AEM_RESP) || (resp_type == MT_AA_RESP);
						cnt_q     <= '0;
						done_q    <= 1'b0;
						n_q       <= '0;
						pend_v_q  <= 1'b0;
						state_q   <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (step) begin
						if (hd.hit) begin
							pend_q   <= hd.res;
							pend_v_q <= 1'b1;
							done_q   <= 1'b1;
							n_q      <= n_q + NW'(1);
							if (cmd_q == CMD_SEND) begin
								next_seq_q <= next_seq_q + 16'd1;
							end
						end
						cnt_q <= cnt_q + CW'(1);
						if (cnt_q == LastIdx) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (!out_busy) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_v_q;
	assign kind      = out_q.kind;
	assign seq_out   = out_q.seq;
	assign tag_out   = out_q.tag;
	assign flag_out  = out_q.flag;
	assign slot      = out_q.slot;
	assign found     = out_q.found;
	assign last      = out_last_q;

endmodule

/* rtl/ict_checker.sv */
// ----------------------------------------------------------------------------
// ict_checker
// Port-level checks for the inflight command tracker.
// ----------------------------------------------------------------------------
`include "inflight_command_tracker_assert.svh"

module ict_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [15:0] cfg_wdata,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  cmd,
	input logic [15:0] tag,
	input logic        notify_flag,
	input logic [15:0] resp_seq,
	input logic [3:0]  resp_type,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  kind,
	input logic [15:0] seq_out,
	input logic [15:0] tag_out,
	input logic        flag_out,
	input logic [3:0]  slot,
	input logic        found,
	input logic        last
);
	import ict_pkg::*;

	`ICT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
	`ICT_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`ICT_ASSERT_NOW(a_kind_range, out_valid, kind <= K_QUERY)
	`ICT_ASSERT_NOW(a_found_query, out_valid && found, kind == K_QUERY)
	`ICT_ASSERT_NOW(a_single_last, out_valid && kind != K_RESEND && kind != K_TIMEOUT, last)

endmodule

bind inflight_command_tracker ict_checker u_ict_checker (.*);

/* verif/inflight_command_tracker_checker.sv */
// ----------------------------------------------------------------------------
// inflight_command_tracker_checker
// Watches both channels of the tracker, predicts every result and compares.
// ----------------------------------------------------------------------------
module inflight_command_tracker_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [15:0] tag,
	input  logic        notify_flag,
	input  logic [15:0] resp_seq,
	input  logic [3:0]  resp_type,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [3:0]  kind,
	input  logic [15:0] seq_out,
	input  logic [15:0] tag_out,
	input  logic        flag_out,
	input  logic [3:0]  slot,
	input  logic        found,
	input  logic        last,
	output int          fail_count,
	output int          pending_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import ict_pkg::*;

	localparam int DEPTH = 16;

	typedef struct packed {
		res_t r;
		logic last;
	} outcome_t;

	entry_t     table_q [DEPTH];
	logic [15:0] seq_ctr;
	logic [15:0] tmo_ticks;
	outcome_t   outcome_q [$];

	assign pending_count = outcome_q.size();

	function automatic outcome_t make_outcome(logic [3:0] k, int s, logic f);
		outcome_t o;
		o = '0;
		o.r.kind = k;
		o.last = 1'b1;
		if (s >= 0) begin
			o.r.seq = table_q[s].seq;
			o.r.tag = table_q[s].tag;
			o.r.flag = table_q[s].flag;
			o.r.slot = s[3:0];
		end
		o.r.found = f;
		return o;
	endfunction

	// append at the tail of the expected list
	function automatic void queue_outcome(outcome_t o);
		outcome_q = {outcome_q, o};
	endfunction

	// apply one item to the table copy and queue what it causes
	task automatic track_item(logic [1:0] c, logic [15:0] tg, logic nf,
			logic [15:0] rs, logic [3:0] mt);
		int n;
		bit done;
		n = 0;
		done = 0;
		case (c)
			CMD_SEND: begin
				for (int i = 0; i < DEPTH && !done; i++)
					if (!table_q[i].valid) begin
						table_q[i].valid = 1'b1;
						table_q[i].seq = seq_ctr;
						table_q[i].tag = tg;
						table_q[i].flag = nf;
						table_q[i].retried = 1'b0;
						table_q[i].timer = tmo_ticks;
						seq_ctr++;
						queue_outcome(make_outcome(K_SENT, i, 1'b0));
						done = 1;
					end
				if (!done) queue_outcome(make_outcome(K_FULL, -1, 1'b0));
			end
			CMD_RESP: begin
				if (mt != MT_AEM_RESP && mt != MT_AA_RESP) begin
					queue_outcome(make_outcome(K_BAD_TYPE, -1, 1'b0));
				end else begin
					for (int i = 0; i < DEPTH && !done; i++)
						if (table_q[i].valid && table_q[i].seq == rs) begin
							queue_outcome(make_outcome(K_MATCHED, i, 1'b0));
							table_q[i].valid = 1'b0;
							done = 1;
						end
					if (!done) queue_outcome(make_outcome(K_UNMATCHED, -1, 1'b0));
				end
			end
			CMD_TICK: begin
				for (int i = 0; i < DEPTH; i++) begin
					if (!table_q[i].valid) continue;
					if (table_q[i].timer > 1) begin
						table_q[i].timer--;
						continue;
					end
					if (n >= 16) continue;
					if (n > 0) outcome_q[$].last = 1'b0;
					if (!table_q[i].retried) begin
						table_q[i].retried = 1'b1;
						table_q[i].timer = tmo_ticks;
						queue_outcome(make_outcome(K_RESEND, i, 1'b0));
					end else begin
						queue_outcome(make_outcome(K_TIMEOUT, i, 1'b0));
						table_q[i].valid = 1'b0;
					end
					n++;
				end
				if (n == 0) queue_outcome(make_outcome(K_TICK_DONE, -1, 1'b0));
			end
			default: begin
				for (int i = 0; i < DEPTH && !done; i++)
					if (table_q[i].valid && table_q[i].tag == tg) begin
						queue_outcome(make_outcome(K_QUERY, i, 1'b1));
						done = 1;
					end
				if (!done) queue_outcome(make_outcome(K_QUERY, -1, 1'b0));
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) table_q[i] = '0;
			seq_ctr = '0;
			tmo_ticks = TMO_RESET;
			outcome_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) tmo_ticks = cfg_wdata;
			if (in_valid && !in_stall)
				track_item(cmd, tag, notify_flag, resp_seq, resp_type);
			if (out_valid && !out_stall) begin
				if (outcome_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result exp none got kind=%0d seq=%0d",
							kind, seq_out);
				end else begin
					want = outcome_q.pop_front();
					if (want.r.kind !== kind || want.r.seq !== seq_out
							|| want.r.tag !== tag_out || want.r.flag !== flag_out
							|| want.r.slot !== slot || want.r.found !== found
							|| want.last !== last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch exp k%0d s%0d t%0d f%0d sl%0d fd%0d l%0d %s%0d s%0d t%0d f%0d sl%0d fd%0d l%0d",
								want.r.kind, want.r.seq, want.r.tag, want.r.flag,
								want.r.slot, want.r.found, want.last, "got k",
								kind, seq_out, tag_out, flag_out, slot, found, last);
					end
				end
			end
		end
	end
endmodule

/* verif/tb_inflight_command_tracker.sv */
// ----------------------------------------------------------------------------
// tb_inflight_command_tracker
// Directed and random items into the tracker, checked by a separate checker.
// ----------------------------------------------------------------------------
module tb_inflight_command_tracker;
	timeunit 1ns;
	timeprecision 1ps;
	import ict_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [15:0] cfg_wdata = '0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  cmd = CMD_TICK;
	logic [15:0] tag = '0;
	logic        notify_flag = 0;
	logic [15:0] resp_seq = '0;
	logic [3:0]  resp_type = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [3:0]  kind;
	logic [15:0] seq_out, tag_out;
	logic        flag_out, found, last;
	logic [3:0]  slot;
	int          fail_count, pending_count;
	int          cycle_count = 0;
	bit          hold_off = 0;

	// seqs handed out so far, so responses can hit live entries
	logic [15:0] issued_seq = '0;

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	inflight_command_tracker dut (.*);

	inflight_command_tracker_checker u_chk (.*);

	// safety net: roughly 400 items, each walked through the ring, plus stalled results and holds
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > 600000) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: its own stall pattern, plus a long hold-off when asked
	always @(negedge clk) begin
		if (hold_off) out_stall <= 1;
		else case ($urandom_range(0, 3))
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= ($urandom_range(0, 1) == 0);
			default: out_stall <= out_stall;
		endcase
	end

	// present one item and hold it until accepted
	task automatic send_item(logic [1:0] c, logic [15:0] tg, logic nf,
			logic [15:0] rs, logic [3:0] mt);
		cmd <= c;
		tag <= tg;
		notify_flag <= nf;
		resp_seq <= rs;
		resp_type <= mt;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		in_valid <= 0;
		@(negedge clk);
	endtask

	// random gap between bursts
	task automatic idle_gap();
		int g;
		g = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
		repeat (g) @(negedge clk);
	endtask

	task automatic random_item();
		logic [1:0] c;
		logic [3:0] mt;
		logic [15:0] rs;
		c = 2'($urandom_range(0, 3));
		mt = $urandom_range(0, 4) == 0 ? 4'($urandom) : ($urandom_range(0, 1) ? MT_AEM_RESP : MT_AA_RESP);
		rs = $urandom_range(0, 3) == 0 ? 16'($urandom) : issued_seq - 16'($urandom_range(1, 20));
		if (c == CMD_SEND) issued_seq++;
		send_item(c, $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom),
			1'($urandom_range(0, 1)), rs, mt);
	endtask

	// write the timeout with the table quiet
	task automatic write_timeout(logic [15:0] v);
		while (pending_count != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		cfg_wdata <= v;
		cfg_we <= 1;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	initial begin
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: fill the table past full with extreme fields, short timers
		write_timeout(16'd0);
		for (int i = 0; i < 17; i++) begin
			send_item(CMD_SEND, i == 0 ? 16'hFFFF : 16'(i), i[0], '0, '0);
			if (i < 16) issued_seq++;
		end
		send_item(CMD_QUERY, 16'hFFFF, 1'b0, '0, '0);
		send_item(CMD_QUERY, 16'h1234, 1'b0, '0, '0);
		send_item(CMD_RESP, '0, 1'b0, 16'hFFFF, 4'hF);
		send_item(CMD_RESP, '0, 1'b0, 16'd3, MT_AEM_RESP);
		send_item(CMD_RESP, '0, 1'b0, 16'd4, MT_AA_RESP);
		send_item(CMD_RESP, '0, 1'b0, 16'hFFFF, MT_AA_RESP);
		send_item(CMD_TICK, '0, 1'b0, '0, '0);  // all resend
		send_item(CMD_TICK, '0, 1'b0, '0, '0);  // all time out
		send_item(CMD_TICK, '0, 1'b0, '0, '0);  // nothing left

		// long receiver hold-off while items keep coming
		write_timeout(16'd65535);
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			for (int i = 0; i < 20; i++) begin
				send_item(CMD_SEND, 16'($urandom), 1'b1, '0, '0);
				issued_seq++;
			end
		join
		send_item(CMD_TICK, '0, 1'b0, '0, '0);

		// random phases at several timeouts
		for (int ph = 0; ph < 4; ph++) begin
			write_timeout(ph == 0 ? 16'd1 : ph == 1 ? 16'd3 : ph == 2 ? 16'd250 : 16'd7);
			for (int n = 0; n < 75; ) begin
				int b;
				b = $urandom_range(1, 12);
				for (int j = 0; j < b; j++) begin
					random_item();
					n++;
				end
				idle_gap();
			end
		end

		while (pending_count != 0) @(negedge clk);
		repeat (60) @(negedge clk);
		if (fail_count == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule
